>>> rtl/fractal_value_noise_2d_core_defines.svh
// Assertion macros shared by the noise core
`ifndef FRACTAL_VALUE_NOISE_2D_CORE_DEFINES_SVH
`define FRACTAL_VALUE_NOISE_2D_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked while out of reset
`define FVN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fvn assertion failed");
// Checked during reset as well
`define FVN_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fvn reset assertion failed");
`else
`define FVN_ASSERT(lbl, prop)
`define FVN_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/fvn_pkg.sv
package fvn_pkg;

  localparam int XW      = 16;  // sample coordinate width
  localparam int FW      = 24;  // frequency register width
  localparam int SEED_W  = 8;
  localparam int OC_W    = 6;
  localparam int VW      = 16;  // noise value width
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 24;

  localparam logic [CFG_IW-1:0] CFG_SEED      = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_FREQUENCY = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_OCTAVES   = 2'd2;

  localparam logic [SEED_W-1:0] SEED_RST = 8'd42;
  localparam logic [FW-1:0]     FREQ_RST = 24'd655;
  localparam logic [OC_W-1:0]   OCT_RST  = 6'd20;

  typedef struct packed {
    logic              adv;
    logic [SEED_W-1:0] seed;
  } oct_ctl_t;

  localparam logic [7:0] HASH_TABLE [256] = '{
    8'd208,8'd34,8'd231,8'd213,8'd32,8'd248,8'd233,8'd56,8'd161,8'd78,8'd24,8'd140,
    8'd71,8'd48,8'd140,8'd254,8'd245,8'd255,8'd247,8'd247,8'd40,8'd185,8'd248,8'd251,
    8'd245,8'd28,8'd124,8'd204,8'd204,8'd76,8'd36,8'd1,8'd107,8'd28,8'd234,8'd163,
    8'd202,8'd224,8'd245,8'd128,8'd167,8'd204,8'd9,8'd92,8'd217,8'd54,8'd239,8'd174,
    8'd173,8'd102,8'd193,8'd189,8'd190,8'd121,8'd100,8'd108,8'd167,8'd44,8'd43,8'd77,
    8'd180,8'd204,8'd8,8'd81,8'd70,8'd223,8'd11,8'd38,8'd24,8'd254,8'd210,8'd210,
    8'd177,8'd32,8'd81,8'd195,8'd243,8'd125,8'd8,8'd169,8'd112,8'd32,8'd97,8'd53,
    8'd195,8'd13,8'd203,8'd9,8'd47,8'd104,8'd125,8'd117,8'd114,8'd124,8'd165,8'd203,
    8'd181,8'd235,8'd193,8'd206,8'd70,8'd180,8'd174,8'd0,8'd167,8'd181,8'd41,8'd164,
    8'd30,8'd116,8'd127,8'd198,8'd245,8'd146,8'd87,8'd224,8'd149,8'd206,8'd57,8'd4,
    8'd192,8'd210,8'd65,8'd210,8'd129,8'd240,8'd178,8'd105,8'd228,8'd108,8'd245,8'd148,
    8'd140,8'd40,8'd35,8'd195,8'd38,8'd58,8'd65,8'd207,8'd215,8'd253,8'd65,8'd85,
    8'd208,8'd76,8'd62,8'd3,8'd237,8'd55,8'd89,8'd232,8'd50,8'd217,8'd64,8'd244,
    8'd157,8'd199,8'd121,8'd252,8'd90,8'd17,8'd212,8'd203,8'd149,8'd152,8'd140,8'd187,
    8'd234,8'd177,8'd73,8'd174,8'd193,8'd100,8'd192,8'd143,8'd97,8'd53,8'd145,8'd135,
    8'd19,8'd103,8'd13,8'd90,8'd135,8'd151,8'd199,8'd91,8'd239,8'd247,8'd33,8'd39,
    8'd145,8'd101,8'd120,8'd99,8'd3,8'd186,8'd86,8'd99,8'd41,8'd237,8'd203,8'd111,
    8'd79,8'd220,8'd135,8'd158,8'd42,8'd30,8'd154,8'd120,8'd67,8'd87,8'd167,8'd135,
    8'd176,8'd183,8'd191,8'd253,8'd115,8'd184,8'd21,8'd233,8'd58,8'd129,8'd233,8'd142,
    8'd39,8'd128,8'd211,8'd118,8'd137,8'd139,8'd255,8'd114,8'd20,8'd218,8'd113,8'd154,
    8'd27,8'd127,8'd246,8'd250,8'd1,8'd8,8'd198,8'd250,8'd209,8'd92,8'd222,8'd173,
    8'd21,8'd88,8'd102,8'd219
  };

  function automatic logic [7:0] hash_byte(input logic [7:0] a);
    return HASH_TABLE[a];
  endfunction

endpackage

>>> rtl/fvn_octave.sv
module fvn_octave import fvn_pkg::*; #(
  parameter int F   = 16,
  parameter int OCT = 0
) (
  input  logic             clk,
  input  oct_ctl_t         ctl,
  input  logic [8+F-1:0]   pos_x,
  input  logic [8+F-1:0]   pos_y,
  output logic [VW-1:0]    v
);

  localparam int PW = 8 + F;
  localparam int LW = 8 + F + 1;
  localparam logic [F:0]   ONE   = (F+1)'(1) << F;
  localparam logic [F+1:0] THREE = (F+2)'(3) << F;

  logic [PW-1:0] px, py;
  logic [7:0]    xi, yi;

  // position of this octave: doubled once per octave, lattice wraps
  assign px = pos_x << OCT;
  assign py = pos_y << OCT;
  assign xi = px[PW-1:F];
  assign yi = py[PW-1:F];

  // stage A: squares and row lookups
  logic [2*F-1:0] ttx_r, tty_r;
  logic [F-1:0]   tx_r, ty_r;
  logic [7:0]     xi_r, row0_r, row1_r;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      ttx_r  <= (2*F)'(px[F-1:0]) * (2*F)'(px[F-1:0]);
      tty_r  <= (2*F)'(py[F-1:0]) * (2*F)'(py[F-1:0]);
      tx_r   <= px[F-1:0];
      ty_r   <= py[F-1:0];
      xi_r   <= xi;
      row0_r <= hash_byte(yi + ctl.seed);
      row1_r <= hash_byte(yi + 8'd1 + ctl.seed);
    end
  end

  // stage B: smoothstep product and corner lookups
  logic [2*F+1:0] sxr_r, syr_r;
  logic [7:0]     c00_r, c10_r, c01_r, c11_r;
  logic [F+1:0]   fx, fy;

  assign fx = THREE - ((F+2)'(tx_r) << 1);
  assign fy = THREE - ((F+2)'(ty_r) << 1);

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      sxr_r <= (2*F+2)'(ttx_r[2*F-1:F]) * (2*F+2)'(fx);
      syr_r <= (2*F+2)'(tty_r[2*F-1:F]) * (2*F+2)'(fy);
      c00_r <= hash_byte(row0_r + xi_r);
      c10_r <= hash_byte(row0_r + xi_r + 8'd1);
      c01_r <= hash_byte(row1_r + xi_r);
      c11_r <= hash_byte(row1_r + xi_r + 8'd1);
    end
  end

  // stage C: cap weights, blend along x
  logic [F+1:0] sxs, sys;
  logic [F:0]   sx, sy;
  logic [LW-1:0] lo_r, hi_r;
  logic [F:0]    sy_r;

  assign sxs = sxr_r[2*F+1:F];
  assign sys = syr_r[2*F+1:F];
  assign sx  = (sxs > (F+2)'(ONE)) ? ONE : sxs[F:0];
  assign sy  = (sys > (F+2)'(ONE)) ? ONE : sys[F:0];

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      lo_r <= LW'(c00_r) * LW'(ONE - sx) + LW'(c10_r) * LW'(sx);
      hi_r <= LW'(c01_r) * LW'(ONE - sx) + LW'(c11_r) * LW'(sx);
      sy_r <= sy;
    end
  end

  // stage D: blend along y, scale to Q0.16
  localparam int BW = LW + F + 2;
  logic [BW-1:0] blend;
  logic [VW-1:0] v_r;

  assign blend = BW'(lo_r) * BW'(ONE - sy_r) + BW'(hi_r) * BW'(sy_r);

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      v_r <= VW'(blend >> (2*F-8));
    end
  end

  assign v = v_r;

endmodule

>>> rtl/fractal_value_noise_2d_core.sv
// Fractal 2D value noise core.
// in_*  : one sample per item, in_tdata = {y_coord, x_coord}, x in the low half.
// out_* : one noise_value per item, unsigned Q0.16 in out_tdata.
// cfg_* : register writes (seed, frequency, octave_count); cfg_ready is always
//         high. Write only while no item is in flight.
// Throughput: one item per cycle unless stalled; all octaves run side by
// side, each an unrolled four-stage unit reading the constant hash table.
// Pipeline: position multiply, four octave stages, the weighted sum tree,
// the octave-count shift and a 16-stage restoring divider by 2^d - 1, one
// quotient bit per stage.
// Stall: the whole pipeline holds while out_tvalid is high and out_tready low;
// in_tready follows, so no item is dropped.
// Reset: clears all valid bits and loads seed 42, frequency 655 and 20
// octaves.
`include "fractal_value_noise_2d_core_defines.svh"
module fractal_value_noise_2d_core import fvn_pkg::*; #(
  parameter int MAX_OCTAVES = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [2*XW-1:0]   in_tdata,   // [15:0] x_coord, [31:16] y_coord
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [VW-1:0]     out_tdata,  // [15:0] noise_value
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int M  = MAX_OCTAVES;
  localparam int F  = FRAC_BITS;
  localparam int PW = 8 + F;
  localparam int W  = VW + M;
  localparam int L  = (M > 1) ? $clog2(M) : 0;
  localparam int P  = 1 << L;
  localparam int DW = $clog2(M + 1);
  localparam int NS = 23 + L;

  // configuration registers
  logic [SEED_W-1:0] seed_r;
  logic [FW-1:0]     freq_r;
  logic [OC_W-1:0]   octc_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RST;
      freq_r <= FREQ_RST;
      octc_r <= OCT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SEED:      seed_r <= cfg_data[SEED_W-1:0];
        CFG_FREQUENCY: freq_r <= cfg_data[FW-1:0];
        CFG_OCTAVES:   octc_r <= cfg_data[OC_W-1:0];
        default:       ;
      endcase
    end
  end

  // clamp the octave count into 1..M
  logic [DW-1:0] d_eff;
  always_comb begin
    if (octc_r == '0)
      d_eff = DW'(1);
    else if (int'(octc_r) > M)
      d_eff = DW'(M);
    else
      d_eff = DW'(octc_r);
  end

  // advance when the output register is empty or being taken
  logic          adv;
  logic [NS-1:0] vld_r;

  assign out_tvalid = vld_r[NS-1];
  assign adv        = !out_tvalid || out_tready;
  assign in_tready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_tvalid};
    end
  end

  // scale coordinates into Q8.F positions
  logic [XW+FW-1:0] prod_x, prod_y;
  logic [PW-1:0]    posx_r, posy_r;

  assign prod_x = (XW+FW)'(in_tdata[XW-1:0]) * (XW+FW)'(freq_r);
  assign prod_y = (XW+FW)'(in_tdata[2*XW-1:XW]) * (XW+FW)'(freq_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      posx_r <= prod_x[PW-1:0];
      posy_r <= prod_y[PW-1:0];
    end
  end

  // octave units
  oct_ctl_t      ctl;
  logic [VW-1:0] v_w [M];

  assign ctl.adv  = adv;
  assign ctl.seed = seed_r;

  for (genvar i = 0; i < M; i++) begin : g_oct
    fvn_octave #(.F(F), .OCT(i)) u_oct (
      .clk   (clk),
      .ctl   (ctl),
      .pos_x (posx_r),
      .pos_y (posy_r),
      .v     (v_w[i])
    );
  end

  // weighted sum tree: leaves at P-1.., root at 0
  logic [W-1:0] tree_r [2*P-1];

  for (genvar p = 0; p < P; p++) begin : g_leaf
    if (p < M) begin : g_used
      always_ff @(posedge clk) begin
        if (adv) begin
          tree_r[P-1+p] <= (DW'(p) < d_eff) ? (W'(v_w[p]) << (M-1-p)) : '0;
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        if (adv) begin
          tree_r[P-1+p] <= '0;
        end
      end
    end
  end

  for (genvar n = 0; n < P-1; n++) begin : g_node
    always_ff @(posedge clk) begin
      if (adv) begin
        tree_r[n] <= tree_r[2*n+1] + tree_r[2*n+2];
      end
    end
  end

  // drop the unused weight bits
  logic [W-1:0]  acc_r;
  logic [DW-1:0] sh;

  assign sh = DW'(M) - d_eff;

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r <= tree_r[0] >> sh;
    end
  end

  // restoring divide by 2^d - 1, one quotient bit per stage
  logic [W-1:0]  dv;
  logic [W-1:0]  rem_r [VW-1];
  logic [VW-1:0] q_r   [VW];

  assign dv = (W'(1) << d_eff) - W'(1);

  for (genvar j = 0; j < VW; j++) begin : g_div
    logic [W-1:0]  rin;
    logic [VW-1:0] qin;
    logic [W-1:0]  trial;
    logic          take;

    if (j == 0) begin : g_first
      assign rin = acc_r;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[j-1];
      assign qin = q_r[j-1];
    end

    assign trial = dv << (VW-1-j);
    assign take  = rin >= trial;

    if (j < VW-1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[j] <= take ? rin - trial : rin;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q_r[j] <= qin | (take ? (VW'(1) << (VW-1-j)) : '0);
      end
    end
  end

  assign out_tdata = q_r[VW-1];

  // checks
  `FVN_ASSERT(a_accept_enters, (in_tvalid && in_tready) |=> vld_r[0])
  `FVN_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid)
  `FVN_ASSERT(a_noise_bound, out_tvalid |-> (out_tdata <= 16'd65280))

endmodule
